[design/bfd_pkg.sv]
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants, types and helpers of the box filter downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_COMP   = 4;
  localparam int unsigned MAX_FACTOR = 16;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_COMP;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned FACTOR_W    = 5;
  localparam int unsigned COMP_W      = 3;
  localparam int unsigned CIDX_W      = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned SAMPLE_W    = 8;

  // reciprocal divider: q = (x * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
    18'd131072, 18'd65536, 18'd43691, 18'd32768,
    18'd26215,  18'd21846, 18'd18725, 18'd16384,
    18'd14564,  18'd13108, 18'd11916, 18'd10923,
    18'd10083,  18'd9363,  18'd8739,  18'd8192
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_X_FACTOR     = 3'd2,
    CFG_Y_FACTOR     = 3'd3,
    CFG_COMPONENTS   = 3'd4
  } cfg_idx_e;

  // what the current item does, decided from the position counters
  typedef struct packed {
    logic [CIDX_W-1:0]   comp;
    logic                run_end;
    logic                band_end;
    logic                last_img;
    logic [FACTOR_W-1:0] pixels_in_run;
    logic [FACTOR_W-1:0] rows_in_band;
    logic [ADDR_W-1:0]   addr;
  } step_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_WIDTH)) r = DIM_W'(MAX_WIDTH);
    return r;
  endfunction

  function automatic logic [FACTOR_W-1:0] clamp_factor(logic [FACTOR_W-1:0] v);
    logic [FACTOR_W-1:0] r;
    r = v;
    if (v == '0) r = FACTOR_W'(1);
    else if (v > FACTOR_W'(MAX_FACTOR)) r = FACTOR_W'(MAX_FACTOR);
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] clamp_comp(logic [COMP_W-1:0] v);
    logic [COMP_W-1:0] r;
    r = v;
    if (v == '0) r = COMP_W'(1);
    else if (v > COMP_W'(MAX_COMP)) r = COMP_W'(MAX_COMP);
    return r;
  endfunction

endpackage

`default_nettype wire

[design/bfd_if.sv]
// ----------------------------------------------------------------------------
// bfd_if
// Valid/ready channels of the box filter downscaler: sample in, result out,
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [bfd_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bfd_result_if;
  logic                          valid;
  logic                          ready;
  logic [bfd_pkg::SAMPLE_W-1:0]  average;
  logic                          last_of_image;
  modport source (output valid, output average, output last_of_image, input ready);
  modport sink   (input valid, input average, input last_of_image, output ready);
endinterface

interface bfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfd_pkg::CFG_IDX_W-1:0]   index;
  logic [bfd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/bfd_line_ram.sv]
// ----------------------------------------------------------------------------
// bfd_line_ram
// Line store of per-column row average sums, one write and one registered
// read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_line_ram (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire [bfd_pkg::ADDR_W-1:0]  waddr_i,
  input  wire [bfd_pkg::SUM_W-1:0]   wdata_i,
  input  wire                        re_i,
  input  wire [bfd_pkg::ADDR_W-1:0]  raddr_i,
  output logic [bfd_pkg::SUM_W-1:0]  rdata_o
);
  import bfd_pkg::*;

  logic [SUM_W-1:0] mem_q [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/bfd_recip_div.sv]
// ----------------------------------------------------------------------------
// bfd_recip_div
// Divides a 12-bit value by 1..16 with truncation through a reciprocal
// table; the quotient is registered on enable and then holds.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_recip_div (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire [bfd_pkg::SUM_W-1:0]     dividend_i,
  input  wire [bfd_pkg::FACTOR_W-1:0]  divisor_i,
  output logic [bfd_pkg::SUM_W-1:0]    quotient_o
);
  import bfd_pkg::*;

  logic [PROD_W-1:0]  prod_q;
  logic [RECIP_W-1:0] recip;
  logic [FACTOR_W-1:0] dm1;

  // divisor is 1..16, so divisor-1 fits the table index
  assign dm1   = divisor_i - FACTOR_W'(1);
  assign recip = RECIP_TABLE[dm1[3:0]];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(dividend_i) * PROD_W'(recip);
    end
  end

  assign quotient_o = prod_q[RECIP_SHIFT +: SUM_W];

endmodule

`default_nettype wire

[design/bfd_ctrl.sv]
// ----------------------------------------------------------------------------
// bfd_ctrl
// Register file and raster position counters; tells what each item does and
// where its column sum lives in the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  bfd_cfg_if.sink        cfg_if,
  input  wire            advance_i,
  output bfd_pkg::step_t step_o,
  output logic           restart_o
);
  import bfd_pkg::*;

  logic [DIM_W-1:0]    width_q, height_q;
  logic [FACTOR_W-1:0] xf_q, yf_q;
  logic [COMP_W-1:0]   ncomp_q;

  logic [DIM_W-1:0]    w, h;
  logic [FACTOR_W-1:0] xf, yf;
  logic [COMP_W-1:0]   nc;

  logic [POS_W-1:0]    col_q, row_q;
  logic [CIDX_W-1:0]   comp_q;
  logic [FACTOR_W-1:0] pir_q, rib_q;
  logic [ADDR_W-1:0]   base_q;

  logic [CIDX_W-1:0]   c;
  logic                row_end, run_end, last_row, band_end, last_comp;
  logic                cfg_hit;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_if.index)
      CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_X_FACTOR,
      CFG_Y_FACTOR, CFG_COMPONENTS: cfg_hit = 1'b1;
      default:                      cfg_hit = 1'b0;
    endcase
  end

  assign restart_o = cfg_if.valid & cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      xf_q     <= FACTOR_W'(1);
      yf_q     <= FACTOR_W'(1);
      ncomp_q  <= COMP_W'(1);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_if.data;
        CFG_IMAGE_HEIGHT: height_q <= cfg_if.data;
        CFG_X_FACTOR:     xf_q     <= cfg_if.data[FACTOR_W-1:0];
        CFG_Y_FACTOR:     yf_q     <= cfg_if.data[FACTOR_W-1:0];
        CFG_COMPONENTS:   ncomp_q  <= cfg_if.data[COMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign w  = clamp_dim(width_q);
  assign h  = clamp_dim(height_q);
  assign xf = clamp_factor(xf_q);
  assign yf = clamp_factor(yf_q);
  assign nc = clamp_comp(ncomp_q);

  always_comb begin
    c         = ({1'b0, comp_q} >= nc) ? '0 : comp_q;
    row_end   = ({1'b0, col_q} + DIM_W'(1)) >= w;
    run_end   = ((pir_q + FACTOR_W'(1)) >= xf) || row_end;
    last_row  = ({1'b0, row_q} + DIM_W'(1)) >= h;
    band_end  = ((rib_q + FACTOR_W'(1)) >= yf) || last_row;
    last_comp = ({1'b0, c} + COMP_W'(1)) >= nc;

    step_o.comp          = c;
    step_o.run_end       = run_end;
    step_o.band_end      = band_end;
    step_o.last_img      = last_row & row_end & last_comp;
    step_o.pixels_in_run = pir_q;
    step_o.rows_in_band  = rib_q;
    step_o.addr          = base_q + ADDR_W'(c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      comp_q <= '0;
      pir_q  <= '0;
      rib_q  <= '0;
      base_q <= '0;
    end else if (restart_o) begin
      col_q  <= '0;
      row_q  <= '0;
      comp_q <= '0;
      pir_q  <= '0;
      rib_q  <= '0;
      base_q <= '0;
    end else if (advance_i) begin
      if (!last_comp) begin
        comp_q <= c + CIDX_W'(1);
      end else begin
        comp_q <= '0;
        pir_q  <= run_end ? '0 : pir_q + FACTOR_W'(1);
        if (!row_end) begin
          col_q <= col_q + POS_W'(1);
          // next block column starts nc entries further on
          if (run_end) begin
            base_q <= base_q + ADDR_W'(nc);
          end
        end else begin
          col_q  <= '0;
          base_q <= '0;
          if (last_row) begin
            row_q <= '0;
            rib_q <= '0;
          end else begin
            row_q <= row_q + POS_W'(1);
            rib_q <= band_end ? '0 : rib_q + FACTOR_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/box_filter_downscale.sv]
// ----------------------------------------------------------------------------
// box_filter_downscale
// Averages x_factor by y_factor pixel blocks per component of a raster byte
// stream, keeping per-column row averages in a line store.
// ----------------------------------------------------------------------------
// An item that closes no run is taken in S_IDLE; one that closes a run also
// passes S_DIV and S_COL, and S_AVG when it also closes a block, set by the
// read-modify-write of the line store around the shared reciprocal divider.
// In S_AVG the result is loaded once the output register is free.
// Reset is asynchronous, active low: registers return to 1 and counters and
// run sums to zero; the line store is not cleared and needs no clearing pass.
`default_nettype none

module box_filter_downscale (
  input  wire            clk_i,
  input  wire            rst_ni,
  bfd_sample_if.sink     in_if,
  bfd_result_if.source   out_if,
  bfd_cfg_if.sink        cfg_if
);
  import bfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_COL  = 4'b0100,
    S_AVG  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  step_t step, st_q;
  logic  restart;
  logic  in_acc;

  logic [SUM_W-1:0] run_sum_q [MAX_COMP];
  logic [SUM_W-1:0] sum, sum_q;

  logic                div_en;
  logic [SUM_W-1:0]    div_x;
  logic [FACTOR_W-1:0] div_d;
  logic [SUM_W-1:0]    div_q;

  logic             ram_we;
  logic [SUM_W-1:0] ram_rdata;
  logic [SUM_W-1:0] col_sum;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_avg_q;
  logic                out_last_q;
  logic                out_load;

  bfd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_if    (cfg_if),
    .advance_i (in_acc),
    .step_o    (step),
    .restart_o (restart)
  );

  bfd_line_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (st_q.addr),
    .wdata_i (col_sum),
    .re_i    (in_acc),
    .raddr_i (step.addr),
    .rdata_o (ram_rdata)
  );

  bfd_recip_div u_div (
    .clk_i      (clk_i),
    .en_i       (div_en),
    .dividend_i (div_x),
    .divisor_i  (div_d),
    .quotient_o (div_q)
  );

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;

  assign sum = run_sum_q[step.comp] + SUM_W'(in_if.sample);

  // first row of a band starts the column sum afresh
  assign col_sum = (st_q.rows_in_band == '0) ? div_q : ram_rdata + div_q;

  always_comb begin
    state_d  = state_q;
    div_en   = 1'b0;
    div_x    = sum_q;
    div_d    = st_q.pixels_in_run + FACTOR_W'(1);
    ram_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && step.run_end) state_d = S_DIV;
      end
      S_DIV: begin
        div_en  = 1'b1;
        state_d = S_COL;
      end
      S_COL: begin
        if (st_q.band_end) begin
          div_en  = 1'b1;
          div_x   = col_sum;
          div_d   = st_q.rows_in_band + FACTOR_W'(1);
          state_d = S_AVG;
        end else begin
          ram_we  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_AVG: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_COMP; i++) run_sum_q[i] <= '0;
    end else if (restart) begin
      for (int i = 0; i < MAX_COMP; i++) run_sum_q[i] <= '0;
    end else if (in_acc) begin
      run_sum_q[step.comp] <= step.run_end ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st_q  <= step;
      sum_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_avg_q  <= div_q[SAMPLE_W-1:0];
      out_last_q <= st_q.last_img;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.average       = out_avg_q;
  assign out_if.last_of_image = out_last_q;

endmodule

`default_nettype wire
